// ===== hw/rtl/cohp_pkg.sv =====
// Shared types, constants and field helpers for the cpio odc header parser.
package cohp_pkg;

	localparam int HdrLen   = 76;
	localparam int PosW     = 7;
	localparam int ShortW   = 18;
	localparam int LongW    = 33;
	localparam int NumShort = 8;
	localparam int NumLong  = 2;
	localparam int NumField = 11;
	localparam int FieldW   = 4;
	localparam int KindW    = 3;
	localparam int ByteW    = 8;
	localparam int OutDataW = 224;

	localparam logic [PosW-1:0]   LastPos    = PosW'(HdrLen - 1);
	localparam logic [ShortW-1:0] MagicValue = 18'o070707;

	// Result kinds
	localparam logic [KindW-1:0] KindHdrName  = 3'd0;
	localparam logic [KindW-1:0] KindHdrOnly  = 3'd1;
	localparam logic [KindW-1:0] KindName     = 3'd2;
	localparam logic [KindW-1:0] KindNameLast = 3'd3;
	localparam logic [KindW-1:0] KindBadMagic = 3'd4;

	// Field indexes: magic, dev .. rdev, mtime, name size, file size
	localparam logic [FieldW-1:0] FldMagic    = 4'd0;
	localparam logic [FieldW-1:0] FldDev      = 4'd1;
	localparam logic [FieldW-1:0] FldRdev     = 4'd7;
	localparam logic [FieldW-1:0] FldMtime    = 4'd8;
	localparam logic [FieldW-1:0] FldNameSize = 4'd9;
	localparam logic [FieldW-1:0] FldFileSize = 4'd10;

	localparam logic [PosW-1:0] FieldStart [NumField] = '{
		7'd0, 7'd6, 7'd12, 7'd18, 7'd24, 7'd30, 7'd36, 7'd42, 7'd48, 7'd59, 7'd65
	};

	// Byte arriving at the input register
	typedef struct packed {
		logic             vld;
		logic [ByteW-1:0] data;
	} cohp_in_t;

	// One result item
	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic [ShortW-1:0] dev;
		logic [ShortW-1:0] ino;
		logic [ShortW-1:0] mode;
		logic [ShortW-1:0] uid;
		logic [ShortW-1:0] gid;
		logic [ShortW-1:0] nlink;
		logic [ShortW-1:0] rdev;
		logic [LongW-1:0]  mtime;
		logic [ShortW-1:0] name_size;
		logic [LongW-1:0]  file_size;
		logic [ByteW-1:0]  name_byte;
	} cohp_result_t;

	// Map a header byte position to its field
	function automatic logic [FieldW-1:0] field_of(input logic [PosW-1:0] pos);
		logic [FieldW-1:0] f;
		f = '0;
		for (int i = 1; i < NumField; i++) begin
			if (pos >= FieldStart[i]) begin
				f = FieldW'(i);
			end
		end
		return f;
	endfunction

	// True on the first byte of any field
	function automatic logic is_start(input logic [PosW-1:0] pos);
		logic s;
		s = 1'b0;
		for (int i = 0; i < NumField; i++) begin
			if (pos == FieldStart[i]) begin
				s = 1'b1;
			end
		end
		return s;
	endfunction

	// Next value of an 18-bit field accumulator
	function automatic logic [ShortW-1:0] upd_short(input logic [ShortW-1:0] cur,
			input logic start, input logic grow, input logic [2:0] d);
		logic [ShortW-1:0] base;
		base = start ? '0 : cur;
		return grow ? {base[ShortW-4:0], d} : base;
	endfunction

	// Next value of a 33-bit field accumulator
	function automatic logic [LongW-1:0] upd_long(input logic [LongW-1:0] cur,
			input logic start, input logic grow, input logic [2:0] d);
		logic [LongW-1:0] base;
		base = start ? '0 : cur;
		return grow ? {base[LongW-4:0], d} : base;
	endfunction

endpackage

// ===== hw/rtl/cohp_in_reg.sv =====
// Input register stage: captures one archive byte per transaction.
module cohp_in_reg
	import cohp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [ByteW-1:0] s_axis_tdata,   // in_byte
	input  logic             take,
	output cohp_in_t         in_s1
);

	logic             vld_s1;
	logic [ByteW-1:0] data_s1;

	assign s_axis_tready = !vld_s1 || take;
	assign in_s1         = '{vld: vld_s1, data: data_s1};

	// Hold the byte until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	// Load payload on each accepted transaction
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
		end
	end

endmodule

// ===== hw/rtl/cohp_parse.sv =====
// Header parser core: field accumulators, byte position and name pass-through.
module cohp_parse
	import cohp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cohp_in_t     in_s1,
	input  logic         slot_free,
	output logic         take,
	output logic         res_vld,
	output cohp_result_t res
);

	logic              phase_q;
	logic [PosW-1:0]   pos_q;
	logic              stop_q;
	logic [ShortW-1:0] magic_q;
	logic [ShortW-1:0] short_q [NumShort];
	logic [LongW-1:0]  long_q [NumLong];
	logic [ShortW-1:0] rem_q;

	logic              phase_d;
	logic [PosW-1:0]   pos_d;
	logic              stop_d;
	logic [ShortW-1:0] magic_d;
	logic [ShortW-1:0] short_d [NumShort];
	logic [LongW-1:0]  long_d [NumLong];
	logic [ShortW-1:0] rem_d;

	logic [FieldW-1:0] fidx;
	logic [2:0]        sidx;
	logic              start;
	logic              digit;
	logic              grow;
	logic [2:0]        dval;
	logic              produces;

	assign fidx     = field_of(pos_q);
	assign sidx     = 3'(fidx - FldDev);
	assign start    = is_start(pos_q);
	assign digit    = (in_s1.data[7:3] == 5'b00110);
	assign dval     = in_s1.data[2:0];
	assign grow     = digit && (start || !stop_q);
	assign produces = phase_q || (pos_q == LastPos);
	assign take     = in_s1.vld && (!produces || slot_free);
	assign res_vld  = take && produces;

	// Work out next state and the result for the byte in the input register
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		stop_d  = stop_q;
		magic_d = magic_q;
		short_d = short_q;
		long_d  = long_q;
		rem_d   = rem_q;
		res     = '0;
		if (phase_q) begin
			// Pass a name byte through, mark the last one
			res.name_byte = in_s1.data;
			if (rem_q <= ShortW'(1)) begin
				res.kind = KindNameLast;
				rem_d    = '0;
				phase_d  = 1'b0;
				pos_d    = '0;
			end else begin
				res.kind = KindName;
				rem_d    = rem_q - ShortW'(1);
			end
		end else begin
			stop_d = start ? !digit : (stop_q || !digit);
			// Advance the accumulator of the current field
			if (fidx == FldMagic) begin
				magic_d = upd_short(magic_q, start, grow, dval);
			end else if (fidx <= FldRdev) begin
				short_d[sidx] = upd_short(short_q[sidx], start, grow, dval);
			end else if (fidx == FldMtime) begin
				long_d[0] = upd_long(long_q[0], start, grow, dval);
			end else if (fidx == FldNameSize) begin
				short_d[NumShort-1] = upd_short(short_q[NumShort-1], start, grow, dval);
			end else begin
				long_d[1] = upd_long(long_q[1], start, grow, dval);
			end
			if (pos_q == LastPos) begin
				pos_d = '0;
				if (magic_d != MagicValue) begin
					res.kind = KindBadMagic;
				end else begin
					res.dev       = short_d[0];
					res.ino       = short_d[1];
					res.mode      = short_d[2];
					res.uid       = short_d[3];
					res.gid       = short_d[4];
					res.nlink     = short_d[5];
					res.rdev      = short_d[6];
					res.mtime     = long_d[0];
					res.name_size = short_d[NumShort-1];
					res.file_size = long_d[1];
					if (short_d[NumShort-1] == '0) begin
						res.kind = KindHdrOnly;
					end else begin
						res.kind = KindHdrName;
						phase_d  = 1'b1;
						rem_d    = short_d[NumShort-1];
					end
				end
			end else begin
				pos_d = pos_q + PosW'(1);
			end
		end
	end

	// Commit state when the byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			pos_q   <= '0;
			stop_q  <= 1'b0;
			magic_q <= '0;
			short_q <= '{default: '0};
			long_q  <= '{default: '0};
			rem_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			stop_q  <= stop_d;
			magic_q <= magic_d;
			short_q <= short_d;
			long_q  <= long_d;
			rem_q   <= rem_d;
		end
	end

endmodule

// ===== hw/rtl/cohp_out_reg.sv =====
// Output register: holds one result transaction until the sink takes it.
module cohp_out_reg
	import cohp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  cohp_result_t        res,
	output logic                slot_free,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,
	output logic [KindW-1:0]    m_axis_tuser
);

	logic         vld_q;
	cohp_result_t res_q;

	assign slot_free     = !vld_q || m_axis_tready;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {6'b0, res_q.name_byte, res_q.file_size, res_q.name_size,
		res_q.mtime, res_q.rdev, res_q.nlink, res_q.gid, res_q.uid, res_q.mode,
		res_q.ino, res_q.dev};

	// Set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			vld_q <= 1'b0;
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== hw/rtl/cpio_odc_header_parser.sv =====
// cpio odc header parser top level.
// Path: each byte is held in the input register while the parser logic works on it; its result
// is then loaded into the output register, or waits while that register still holds an earlier result.
// Throughput: one byte per cycle through the field accumulate between the input register and
// the output register, but a byte that yields a result waits until the sink takes the earlier one.
// Reset (arst_n low) empties both registers and returns the parser to header position 0
// with all field accumulators cleared; no clearing pass follows.
module cpio_odc_header_parser
	import cohp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [ByteW-1:0]    s_axis_tdata,   // in_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// dev, ino, mode, uid, gid, nlink, rdev, mtime, name_size, file_size, name_byte, pad
	output logic [OutDataW-1:0] m_axis_tdata,
	output logic [KindW-1:0]    m_axis_tuser    // kind
);

	cohp_in_t     in_s1;
	cohp_result_t res;
	logic         take;
	logic         res_vld;
	logic         slot_free;

	cohp_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.take          (take),
		.in_s1         (in_s1)
	);

	cohp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_s1     (in_s1),
		.slot_free (slot_free),
		.take      (take),
		.res_vld   (res_vld),
		.res       (res)
	);

	cohp_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (res_vld),
		.res           (res),
		.slot_free     (slot_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
